FILE: sv/rot_pkg.sv
`timescale 1ns / 1ps

package rot_pkg;

  localparam int MaxSide    = 64;
  localparam int PixelBits  = 32;
  localparam int StoreDepth = MaxSide * MaxSide;
  localparam int AddrW      = $clog2(StoreDepth);
  localparam int CntW       = AddrW + 1;
  localparam int PosW       = $clog2(MaxSide);
  localparam int CfgDataW   = 7;
  localparam int CfgIdxW    = 2;
  localparam int QueueDepth = 4;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCntW      = QPtrW + 1;

  typedef enum logic [CfgIdxW-1:0] {
    RegSrcWidth  = 2'd0,
    RegSrcHeight = 2'd1
  } cfg_reg_e;

  typedef enum logic {
    ModeLoad  = 1'b0,
    ModeFetch = 1'b1
  } mode_e;

  // one memory operation for the back end
  typedef struct packed {
    logic                 wr;
    logic [AddrW-1:0]     addr;
    logic [PixelBits-1:0] data;
    logic                 last;
    logic                 not_ready;
  } cmd_t;

endpackage

FILE: sv/image_rotate_90_top.sv
`timescale 1ns / 1ps

// Rotates a frame by 90 degrees clockwise. Load transactions (tuser = 0) write
// source pixels in raster order into a 64 x 64 x 32-bit frame store; fetch
// transactions (tuser = 1) return the rotated frame in raster order, with tlast
// on its final pixel, after which the next frame may be loaded. A fetch before
// the frame is complete returns tuser = 1 with zero data; loads during draining
// are dropped. One transaction is accepted per cycle unless the queue is full or
// cfg_valid_i is high: the front end updates counters and addresses, a 4-entry
// queue decouples it from the back end, which does one frame-store access per
// cycle; reads wait when the output is back-pressured. The frame store is not
// cleared at reset. Register writes (index 0 width, 1 height, 1..64) restart the
// frame; the input is held off in the cycle of a register write.
module image_rotate_90_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rot_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [rot_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [rot_pkg::PixelBits-1:0] s_axis_tdata,  // pixel_in
  input  logic                          s_axis_tuser,  // mode
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [rot_pkg::PixelBits-1:0] m_axis_tdata,  // pixel_out
  output logic                          m_axis_tlast,
  output logic                          m_axis_tuser   // not_ready
);
  import rot_pkg::*;

  logic push, pop, full, empty;
  cmd_t cmd, head;

  assign cfg_ready_o = 1'b1;

  rot_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .item_valid_i (s_axis_tvalid),
    .item_mode_i  (s_axis_tuser),
    .item_pixel_i (s_axis_tdata),
    .full_i       (full),
    .item_ready_o (s_axis_tready),
    .push_o       (push),
    .cmd_o        (cmd)
  );

  rot_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .head_o  (head)
  );

  rot_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .empty_i         (empty),
    .head_i          (head),
    .pop_o           (pop),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .out_pixel_o     (m_axis_tdata),
    .out_last_o      (m_axis_tlast),
    .out_not_ready_o (m_axis_tuser)
  );

  a_nr_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0 && !m_axis_tlast)
    else $error("not-ready result carries data or tlast");

  a_nr_is_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && cmd.not_ready |-> !cmd.wr && !cmd.last)
    else $error("not-ready flag on a write or last command");

  a_last_is_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && cmd.last |-> !cmd.wr)
    else $error("last flag on a write command");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> !(s_axis_tvalid && s_axis_tready))
    else $error("transaction accepted while queue full");

endmodule

FILE: sv/rot_front.sv
`timescale 1ns / 1ps

module rot_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic [rot_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [rot_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                           item_valid_i,
  input  logic                           item_mode_i,
  input  logic [rot_pkg::PixelBits-1:0]  item_pixel_i,
  input  logic                           full_i,
  output logic                           item_ready_o,
  output logic                           push_o,
  output rot_pkg::cmd_t                  cmd_o
);
  import rot_pkg::*;

  localparam int SideW = CfgDataW;
  localparam int ProdW = 2 * SideW;

  logic [SideW-1:0] src_w_q, src_w_d, src_h_q, src_h_d;
  logic [CntW-1:0]  load_cnt_q, load_cnt_d;
  logic [PosW-1:0]  col_q, col_d, row_q, row_d;
  logic             loaded_q, loaded_d;

  logic [SideW-1:0] w, h, src_row;
  logic [ProdW-1:0] total, row_base;
  logic [CntW-1:0]  cnt_inc;
  logic             accept, last_col, last_row, cfg_hit;
  mode_e            mode;

  function automatic logic [SideW-1:0] clamp_side(input logic [SideW-1:0] v);
    logic [SideW-1:0] r;
    r = v;
    if (v == '0) r = SideW'(1);
    else if (v > SideW'(MaxSide)) r = SideW'(MaxSide);
    return r;
  endfunction

  assign w        = clamp_side(src_w_q);
  assign h        = clamp_side(src_h_q);
  assign total    = ProdW'(w) * ProdW'(h);
  assign cnt_inc  = load_cnt_q + CntW'(1);
  assign last_col = (SideW'(col_q) + SideW'(1)) == h;
  assign last_row = (SideW'(row_q) + SideW'(1)) == w;
  assign src_row  = h - SideW'(1) - SideW'(col_q);
  assign row_base = ProdW'(src_row) * ProdW'(w);

  // a register write takes the cycle; the input waits
  assign mode         = mode_e'(item_mode_i);
  assign item_ready_o = !full_i && !cfg_valid_i;
  assign accept       = item_valid_i && item_ready_o;

  always_comb begin
    src_w_d    = src_w_q;
    src_h_d    = src_h_q;
    load_cnt_d = load_cnt_q;
    col_d      = col_q;
    row_d      = row_q;
    loaded_d   = loaded_q;
    push_o     = 1'b0;
    cfg_hit    = 1'b0;
    cmd_o      = '0;

    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegSrcWidth: begin
          src_w_d = cfg_data_i;
          cfg_hit = 1'b1;
        end
        RegSrcHeight: begin
          src_h_d = cfg_data_i;
          cfg_hit = 1'b1;
        end
        default: ;
      endcase
    end

    if (cfg_hit) begin
      load_cnt_d = '0;
      col_d      = '0;
      row_d      = '0;
      loaded_d   = 1'b0;
    end else if (accept) begin
      unique case (mode)
        ModeLoad: begin
          if (!loaded_q) begin
            push_o     = 1'b1;
            cmd_o.wr   = 1'b1;
            cmd_o.addr = load_cnt_q[AddrW-1:0];
            cmd_o.data = item_pixel_i;
            load_cnt_d = cnt_inc;
            loaded_d   = ProdW'(cnt_inc) >= total;
          end
        end
        ModeFetch: begin
          push_o = 1'b1;
          if (!loaded_q) begin
            cmd_o.not_ready = 1'b1;
          end else begin
            cmd_o.addr = AddrW'(row_base + ProdW'(row_q));
            cmd_o.last = last_col && last_row;
            if (last_col && last_row) begin
              load_cnt_d = '0;
              col_d      = '0;
              row_d      = '0;
              loaded_d   = 1'b0;
            end else if (last_col) begin
              col_d = '0;
              row_d = row_q + PosW'(1);
            end else begin
              col_d = col_q + PosW'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q    <= SideW'(MaxSide);
      src_h_q    <= SideW'(MaxSide);
      load_cnt_q <= '0;
      col_q      <= '0;
      row_q      <= '0;
      loaded_q   <= 1'b0;
    end else begin
      src_w_q    <= src_w_d;
      src_h_q    <= src_h_d;
      load_cnt_q <= load_cnt_d;
      col_q      <= col_d;
      row_q      <= row_d;
      loaded_q   <= loaded_d;
    end
  end

endmodule

FILE: sv/rot_cmd_fifo.sv
`timescale 1ns / 1ps

module rot_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  rot_pkg::cmd_t cmd_i,
  input  logic          pop_i,
  output logic          full_o,
  output logic          empty_o,
  output rot_pkg::cmd_t head_o
);
  import rot_pkg::*;

  cmd_t             mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = cnt_q == QCntW'(QueueDepth);
  assign empty_o = cnt_q == '0;
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) cnt_d = cnt_q + QCntW'(1);
    else if (!do_push && do_pop) cnt_d = cnt_q - QCntW'(1);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      if (do_pop) rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      cnt_q <= cnt_d;
    end
  end

endmodule

FILE: sv/rot_back.sv
`timescale 1ns / 1ps

module rot_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          empty_i,
  input  rot_pkg::cmd_t                 head_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [rot_pkg::PixelBits-1:0] out_pixel_o,
  output logic                          out_last_o,
  output logic                          out_not_ready_o
);
  import rot_pkg::*;

  logic [PixelBits-1:0] store [StoreDepth];
  logic [PixelBits-1:0] rdata_q;
  logic                 pend_valid_q, pend_last_q, pend_nr_q;
  logic                 out_valid_q, out_last_q, out_nr_q;
  logic [PixelBits-1:0] out_pixel_q;
  logic                 out_free, pend_free, pend_move, rd_issue;

  assign out_free  = !out_valid_q || out_ready_i;
  assign pend_move = pend_valid_q && out_free;
  assign pend_free = !pend_valid_q || out_free;
  assign pop_o     = !empty_i && (head_i.wr || pend_free);
  assign rd_issue  = pop_o && !head_i.wr;

  always_ff @(posedge clk_i) begin
    if (pop_o && head_i.wr) store[head_i.addr] <= head_i.data;
    if (rd_issue) rdata_q <= store[head_i.addr];
  end

  always_ff @(posedge clk_i) begin
    if (rd_issue) begin
      pend_last_q <= head_i.last;
      pend_nr_q   <= head_i.not_ready;
    end
    if (pend_move) begin
      out_pixel_q <= pend_nr_q ? '0 : rdata_q;
      out_last_q  <= pend_last_q;
      out_nr_q    <= pend_nr_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (rd_issue) pend_valid_q <= 1'b1;
      else if (pend_move) pend_valid_q <= 1'b0;
      if (pend_move) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_pixel_o     = out_pixel_q;
  assign out_last_o      = out_last_q;
  assign out_not_ready_o = out_nr_q;

endmodule
